// ===== design/bte_pkg.sv =====
// Shared constants, types and saturation helper for the truncated power B-spline evaluator.
package bte_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_DEGREE = 3;
    localparam int KNOTS      = 5;
    localparam int WORD_W     = 32;
    localparam int DVD_W      = WORD_W + FRAC_BITS;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int CNT_W      = $clog2(DVD_W + 1);

    localparam logic [PROD_W-1:0] MAG_MIN_NEG = PROD_W'(1) << (WORD_W - 1);
    localparam logic [PROD_W-1:0] MAG_MAX_POS = MAG_MIN_NEG - PROD_W'(1);

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ZERO_GAP  = 2'd1,
        STATUS_SAT       = 2'd2,
        STATUS_BAD_ORDER = 2'd3
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              sat;
    } sat_res_t;

    // Applies the sign to a magnitude and clamps it to the signed word range.
    function automatic sat_res_t sat_signed(input logic neg, input logic [PROD_W-1:0] mag);
        sat_res_t r;
        r.sat   = 1'b0;
        r.value = mag[WORD_W-1:0];
        if (neg) begin
            if (mag > MAG_MIN_NEG) begin
                r.sat   = 1'b1;
                r.value = MAG_MIN_NEG[WORD_W-1:0];
            end else begin
                r.value = -mag[WORD_W-1:0];
            end
        end else if (mag > MAG_MAX_POS) begin
            r.sat   = 1'b1;
            r.value = MAG_MAX_POS[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/bte_serial_unit.sv =====
// Radix-2 shift-add multiplier and restoring divider on unsigned magnitudes.
module bte_serial_unit import bte_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  unit_req_t         req,
    input  logic [WORD_W-1:0] opnd_a,
    input  logic [DVD_W-1:0]  opnd_b,
    output logic              done,
    output logic [PROD_W-1:0] result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    unit_op_t          op_reg, op_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [DVD_W-1:0]  sh_reg, sh_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   trial_sub;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        a_next    = a_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        trial     = {rem_reg, sh_reg[DVD_W-1]};
        trial_sub = trial - {1'b0, a_reg};
        if (req.start) begin
            op_next   = req.op;
            a_next    = opnd_a;
            acc_next  = '0;
            rem_next  = '0;
            busy_next = 1'b1;
            if (req.op == OP_MUL) begin
                sh_next  = {opnd_b[WORD_W-1:0], {FRAC_BITS{1'b0}}};
                cnt_next = CNT_W'(WORD_W);
            end else begin
                sh_next  = opnd_b;
                cnt_next = CNT_W'(DVD_W);
            end
        end else if (busy_reg) begin
            sh_next  = {sh_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (op_reg == OP_MUL) begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (sh_reg[DVD_W-1] ? PROD_W'(a_reg) : '0);
            end else if (trial >= {1'b0, a_reg}) begin
                rem_next = trial_sub[WORD_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[WORD_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== design/bspline_truncated_power_eval_top.sv =====
// Top level: sequencer for the truncated power divided-difference table and final scale.
// One beat is taken only while idle; a bad order skips the powers and divisions and loads
// a zero result with the bad-order status. One shared serial unit does every multiply and divide.
// The next beat is taken in the cycle after the result is loaded, while it waits for the receiver.
// Reset is synchronous and active low; it clears the control state and sets degree to one.
module bspline_truncated_power_eval_top import bte_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wen,
    input  logic [1:0]               cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_x_point,
    input  logic [2:0]               s_order,
    input  logic signed [WORD_W-1:0] s_knot_0,
    input  logic signed [WORD_W-1:0] s_knot_1,
    input  logic signed [WORD_W-1:0] s_knot_2,
    input  logic signed [WORD_W-1:0] s_knot_3,
    input  logic signed [WORD_W-1:0] s_knot_4,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_spline_value,
    output logic [1:0]               m_status
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_POW   = 9'b000000010,
        ST_PMUL  = 9'b000000100,
        ST_ALIGN = 9'b000001000,
        ST_DD    = 9'b000010000,
        ST_DDW   = 9'b000100000,
        ST_FIN   = 9'b001000000,
        ST_FINW  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [1:0]                degree_reg, degree_next;
    logic signed [WORD_W-1:0]  x_reg, x_next;
    logic signed [WORD_W-1:0]  t_reg [KNOTS];
    logic signed [WORD_W-1:0]  t_next [KNOTS];
    logic signed [WORD_W-1:0]  tk_reg [KNOTS];
    logic signed [WORD_W-1:0]  tk_next [KNOTS];
    logic signed [WORD_W-1:0]  e_reg [KNOTS];
    logic signed [WORD_W-1:0]  e_next [KNOTS];
    logic [2:0]                nk_reg, nk_next;
    logic [2:0]                j_reg, j_next;
    logic [2:0]                k_reg, k_next;
    logic [2:0]                off_reg, off_next;
    logic [1:0]                pw_reg, pw_next;
    logic [WORD_W-1:0]         d_reg, d_next;
    logic                      neg_reg, neg_next;
    logic                      sat_reg, sat_next;
    logic [WORD_W-1:0]         res_value_reg, res_value_next;
    status_t                   res_status_reg, res_status_next;
    logic                      m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]         m_value_reg, m_value_next;
    status_t                   m_status_reg, m_status_next;

    unit_req_t                 req;
    logic [WORD_W-1:0]         opnd_a;
    logic [DVD_W-1:0]          opnd_b;
    logic                      unit_done;
    logic [PROD_W-1:0]         unit_res;

    logic [WORD_W:0]           pdiff;
    logic [WORD_W-1:0]         pw_d;
    logic                      pw_dsat;
    logic [WORD_W:0]           den;
    logic [WORD_W:0]           num;
    logic [WORD_W:0]           den_neg;
    logic [WORD_W:0]           num_neg;
    logic [WORD_W:0]           e0_neg;
    logic [WORD_W-1:0]         den_mag;
    logic [WORD_W-1:0]         num_mag;
    logic [WORD_W-1:0]         e0_mag;
    logic [2:0]                lim;
    logic [2:0]                target;
    logic                      bad_order;
    sat_res_t                  pmul_res;
    sat_res_t                  div_res;
    sat_res_t                  fin_res;

    bte_serial_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b),
        .done    (unit_done),
        .result  (unit_res)
    );

    assign pdiff   = {t_reg[0][WORD_W-1], t_reg[0]} - {x_reg[WORD_W-1], x_reg};
    assign pw_dsat = !pdiff[WORD_W] && pdiff[WORD_W-1];
    assign pw_d    = pdiff[WORD_W] ? '0 : (pw_dsat ? MAG_MAX_POS[WORD_W-1:0]
                                                   : pdiff[WORD_W-1:0]);
    assign den     = {tk_reg[0][WORD_W-1], tk_reg[0]} - {t_reg[0][WORD_W-1], t_reg[0]};
    assign num     = {e_reg[1][WORD_W-1], e_reg[1]} - {e_reg[0][WORD_W-1], e_reg[0]};
    assign den_neg = -den;
    assign num_neg = -num;
    assign e0_neg  = -{e_reg[0][WORD_W-1], e_reg[0]};
    assign den_mag = den[WORD_W] ? den_neg[WORD_W-1:0] : den[WORD_W-1:0];
    assign num_mag = num[WORD_W] ? num_neg[WORD_W-1:0] : num[WORD_W-1:0];
    assign e0_mag  = e_reg[0][WORD_W-1] ? e0_neg[WORD_W-1:0] : e_reg[0];
    assign lim     = nk_reg - k_reg;
    assign target  = (k_reg < nk_reg) ? k_reg : ({1'b0, degree_reg} + 3'd1);

    assign bad_order = (degree_reg == 2'd0) || ({1'b0, degree_reg} > 3'(MAX_DEGREE))
                     || (s_order == 3'd0)
                     || ({1'b0, s_order} > ({2'b00, degree_reg} + 4'd2));

    assign pmul_res = sat_signed(1'b0, unit_res >> FRAC_BITS);
    assign div_res  = sat_signed(neg_reg, unit_res);
    assign fin_res  = sat_signed(neg_reg, unit_res >> FRAC_BITS);

    always_comb begin
        state_next      = state_reg;
        degree_next     = degree_reg;
        x_next          = x_reg;
        t_next          = t_reg;
        tk_next         = tk_reg;
        e_next          = e_reg;
        nk_next         = nk_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        off_next        = off_reg;
        pw_next         = pw_reg;
        d_next          = d_reg;
        neg_next        = neg_reg;
        sat_next        = sat_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        req.start       = 1'b0;
        req.op          = OP_MUL;
        opnd_a          = '0;
        opnd_b          = '0;

        if (cfg_wen) begin
            degree_next = cfg_wdata;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_x_point;
                    t_next[0]  = s_knot_0;
                    t_next[1]  = s_knot_1;
                    t_next[2]  = s_knot_2;
                    t_next[3]  = s_knot_3;
                    t_next[4]  = s_knot_4;
                    tk_next[0] = s_knot_0;
                    tk_next[1] = s_knot_1;
                    tk_next[2] = s_knot_2;
                    tk_next[3] = s_knot_3;
                    tk_next[4] = s_knot_4;
                    nk_next    = s_order;
                    j_next     = '0;
                    sat_next   = 1'b0;
                    if (bad_order) begin
                        res_value_next  = '0;
                        res_status_next = STATUS_BAD_ORDER;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_POW;
                    end
                end
            end
            ST_POW: begin
                if (j_reg == 3'(KNOTS)) begin
                    k_next     = 3'd1;
                    off_next   = '0;
                    state_next = ST_ALIGN;
                end else if (j_reg < nk_reg && !pdiff[WORD_W] && degree_reg != 2'd1) begin
                    sat_next   = sat_reg | pw_dsat;
                    d_next     = pw_d;
                    pw_next    = degree_reg - 2'd1;
                    req.start  = 1'b1;
                    opnd_a     = pw_d;
                    opnd_b     = DVD_W'(pw_d);
                    state_next = ST_PMUL;
                end else begin
                    for (int i = 0; i < KNOTS - 1; i++) begin
                        e_next[i] = e_reg[i+1];
                        t_next[i] = t_reg[i+1];
                    end
                    e_next[KNOTS-1] = (j_reg < nk_reg) ? pw_d : '0;
                    t_next[KNOTS-1] = t_reg[0];
                    if (j_reg < nk_reg) begin
                        sat_next = sat_reg | pw_dsat;
                    end
                    j_next = j_reg + 3'd1;
                end
            end
            ST_PMUL: begin
                if (unit_done) begin
                    sat_next = sat_reg | pmul_res.sat;
                    if (pw_reg == 2'd1) begin
                        for (int i = 0; i < KNOTS - 1; i++) begin
                            e_next[i] = e_reg[i+1];
                            t_next[i] = t_reg[i+1];
                        end
                        e_next[KNOTS-1] = pmul_res.value;
                        t_next[KNOTS-1] = t_reg[0];
                        j_next          = j_reg + 3'd1;
                        state_next      = ST_POW;
                    end else begin
                        pw_next   = pw_reg - 2'd1;
                        req.start = 1'b1;
                        opnd_a    = pmul_res.value;
                        opnd_b    = DVD_W'(d_reg);
                    end
                end
            end
            ST_ALIGN: begin
                if (off_reg != target) begin
                    for (int i = 0; i < KNOTS - 1; i++) begin
                        tk_next[i] = tk_reg[i+1];
                    end
                    tk_next[KNOTS-1] = tk_reg[0];
                    off_next         = off_reg + 3'd1;
                end else if (k_reg < nk_reg) begin
                    j_next     = '0;
                    state_next = ST_DD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DD: begin
                if (j_reg == 3'(KNOTS)) begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_ALIGN;
                end else if (j_reg < lim) begin
                    if (den == '0) begin
                        res_value_next  = '0;
                        res_status_next = STATUS_ZERO_GAP;
                        state_next      = ST_DONE;
                    end else begin
                        neg_next   = num[WORD_W] ^ den[WORD_W];
                        req.start  = 1'b1;
                        req.op     = OP_DIV;
                        opnd_a     = den_mag;
                        opnd_b     = {num_mag, {FRAC_BITS{1'b0}}};
                        state_next = ST_DDW;
                    end
                end else begin
                    for (int i = 0; i < KNOTS - 1; i++) begin
                        e_next[i]  = e_reg[i+1];
                        t_next[i]  = t_reg[i+1];
                        tk_next[i] = tk_reg[i+1];
                    end
                    e_next[KNOTS-1]  = e_reg[0];
                    t_next[KNOTS-1]  = t_reg[0];
                    tk_next[KNOTS-1] = tk_reg[0];
                    j_next           = j_reg + 3'd1;
                end
            end
            ST_DDW: begin
                if (unit_done) begin
                    sat_next = sat_reg | div_res.sat;
                    for (int i = 0; i < KNOTS - 1; i++) begin
                        e_next[i]  = e_reg[i+1];
                        t_next[i]  = t_reg[i+1];
                        tk_next[i] = tk_reg[i+1];
                    end
                    e_next[KNOTS-1]  = div_res.value;
                    t_next[KNOTS-1]  = t_reg[0];
                    tk_next[KNOTS-1] = tk_reg[0];
                    j_next           = j_reg + 3'd1;
                    state_next       = ST_DD;
                end
            end
            ST_FIN: begin
                neg_next   = e_reg[0][WORD_W-1] ^ den[WORD_W];
                req.start  = 1'b1;
                opnd_a     = e0_mag;
                opnd_b     = DVD_W'(den_mag);
                state_next = ST_FINW;
            end
            ST_FINW: begin
                if (unit_done) begin
                    res_value_next  = fin_res.value;
                    res_status_next = (sat_reg || fin_res.sat) ? STATUS_SAT : STATUS_OK;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            degree_reg  <= 2'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            degree_reg  <= degree_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        t_reg          <= t_next;
        tk_reg         <= tk_next;
        e_reg          <= e_next;
        nk_reg         <= nk_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        off_reg        <= off_next;
        pw_reg         <= pw_next;
        d_reg          <= d_next;
        neg_reg        <= neg_next;
        sat_reg        <= sat_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_spline_value = m_value_reg;
    assign m_status       = m_status_reg;

endmodule
